// ===== design/lls_pkg.sv =====
package lls_pkg;

    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_TIME_BITS = 32;

    localparam int DB_W    = 8;
    localparam int TYPE_W  = 4;
    localparam int EIDX_W  = 4;
    localparam int LOAD_W  = 16;
    localparam int TNOW_W  = 32;
    localparam int QIDX_W  = 4;

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;

    typedef enum logic [1:0] {
        MODE_SELECT = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_STAMP  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [DB_W-1:0]   db;
        logic [TYPE_W-1:0] qtype;
        logic              lead;
        logic [LOAD_W-1:0] load;
    } t_attr;

    typedef struct packed {
        logic  attr_we;
        logic  time_we;
        logic  valid;
        t_attr attr;
    } t_tbl_wr;

endpackage

// ===== design/lls_table.sv =====
module lls_table
    import lls_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int TIME_BITS = DEF_TIME_BITS,
    localparam int IW       = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tbl_wr              i_wr,
    input  logic [IW-1:0]        i_wr_idx,
    input  logic [TIME_BITS-1:0] i_wr_time,
    input  logic [IW-1:0]        i_rd_addr,
    output logic                 o_rd_valid,
    output t_attr                o_rd_attr,
    output logic [TIME_BITS-1:0] o_rd_time
);

    logic [ENTRIES-1:0]   r_valid;
    t_attr                r_attr_mem [ENTRIES];
    logic [TIME_BITS-1:0] r_time_mem [ENTRIES];
    logic                 r_rd_valid;
    t_attr                r_rd_attr;
    logic [TIME_BITS-1:0] r_rd_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.attr_we) begin
            r_valid[i_wr_idx] <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.attr_we) begin
            r_attr_mem[i_wr_idx] <= i_wr.attr;
        end
        if (i_wr.time_we) begin
            r_time_mem[i_wr_idx] <= i_wr_time;
        end
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_attr  <= r_attr_mem[i_rd_addr];
        r_rd_time  <= r_time_mem[i_rd_addr];
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_attr  = r_rd_attr;
    assign o_rd_time  = r_rd_time;

endmodule

// ===== design/least_loaded_queue_select_top.sv =====
// Least-loaded queue selector. Each transaction on the slave stream is a select,
// a table write or a time stamp (tuser), and each gives exactly one result on the
// master stream. A select reads the table one entry a cycle through its single
// read port, tracking the least-loaded, oldest matching entry of the hinted type
// and the first lead entry of the database in the same pass. Writes, stamps and the
// unused mode go straight to ST_DONE. The block accepts one transaction at a
// time; the result sits in an output register until taken, and no clearing
// pass follows reset.
module least_loaded_queue_select_top
    import lls_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // db_id[7:0], type_id[11:8], hint_present[12], entry_index[16:13],
    // entry_valid[17], entry_lead[18], entry_depth[34:19], time_now[66:35]
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // mode[1:0]
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // found[0], queue_index[4:1], used_fallback[5]
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // input fields
    logic [1:0]        in_mode;
    logic [DB_W-1:0]   in_db;
    logic [TYPE_W-1:0] in_type;
    logic              in_hint;
    logic [EIDX_W-1:0] in_idx;
    logic              in_valid;
    logic              in_lead;
    logic [LOAD_W-1:0] in_depth;
    logic [TNOW_W-1:0] in_time;

    assign in_mode  = s_axis_tuser[1:0];
    assign in_db    = s_axis_tdata[7:0];
    assign in_type  = s_axis_tdata[11:8];
    assign in_hint  = s_axis_tdata[12];
    assign in_idx   = s_axis_tdata[16:13];
    assign in_valid = s_axis_tdata[17];
    assign in_lead  = s_axis_tdata[18];
    assign in_depth = s_axis_tdata[34:19];
    assign in_time  = s_axis_tdata[66:35];

    t_state               r_state, n_state;
    logic [DB_W-1:0]      r_db, n_db;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic                 r_hint, n_hint;
    logic [IW-1:0]        r_addr, n_addr;
    logic                 r_issuing, n_issuing;
    logic                 r_chk, n_chk;
    logic [IW-1:0]        r_chk_idx, n_chk_idx;
    logic                 r_have, n_have;
    logic [IW-1:0]        r_best_idx, n_best_idx;
    logic [LOAD_W-1:0]    r_best_load, n_best_load;
    logic [TIME_BITS-1:0] r_best_time, n_best_time;
    logic                 r_lead_have, n_lead_have;
    logic [IW-1:0]        r_lead_idx, n_lead_idx;
    logic [M_DATA_W-1:0]  r_res, n_res;
    logic                 r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0]  r_m_data, n_m_data;

    t_tbl_wr              tbl_wr;
    logic [IW-1:0]        tbl_wr_idx;
    logic [TIME_BITS-1:0] tbl_wr_time;
    logic                 rd_valid;
    t_attr                rd_attr;
    logic [TIME_BITS-1:0] rd_time;

    logic                 accept;
    logic                 idx_in_range;
    logic [IW+EIDX_W-1:0] in_idx_ext;
    logic [63:0]          time_wide;
    logic                 hit_hint;
    logic                 hit_lead;
    logic                 better;
    logic [IW+QIDX_W-1:0] qidx_ext;
    logic                 use_hint;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_idx_ext    = {{IW{1'b0}}, in_idx};
    assign tbl_wr_idx    = in_idx_ext[IW-1:0];
    assign idx_in_range  = (32'(in_idx) < ENTRIES);
    assign time_wide     = {32'b0, in_time};

    always_comb begin
        tbl_wr            = '0;
        tbl_wr.valid      = in_valid;
        tbl_wr.attr.db    = in_db;
        tbl_wr.attr.qtype = in_type;
        tbl_wr.attr.lead  = in_lead;
        tbl_wr.attr.load  = in_depth;
        tbl_wr_time       = '0;
        if (accept && idx_in_range) begin
            case (in_mode)
                MODE_WRITE: begin
                    tbl_wr.attr_we = 1'b1;
                    tbl_wr.time_we = 1'b1;
                end
                MODE_STAMP: begin
                    tbl_wr.time_we = 1'b1;
                    tbl_wr_time    = time_wide[TIME_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    lls_table #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_wr_idx   (tbl_wr_idx),
        .i_wr_time  (tbl_wr_time),
        .i_rd_addr  (r_addr),
        .o_rd_valid (rd_valid),
        .o_rd_attr  (rd_attr),
        .o_rd_time  (rd_time)
    );

    // shared compare unit: one table entry per cycle
    assign hit_hint = r_chk && rd_valid && (rd_attr.db == r_db) && (rd_attr.qtype == r_type);
    assign hit_lead = r_chk && rd_valid && (rd_attr.db == r_db) && rd_attr.lead;
    assign better   = !r_have || (rd_attr.load < r_best_load) ||
                      ((rd_attr.load == r_best_load) && (rd_time < r_best_time));

    always_comb begin
        n_state     = r_state;
        n_db        = r_db;
        n_type      = r_type;
        n_hint      = r_hint;
        n_addr      = r_addr;
        n_issuing   = r_issuing;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_load = r_best_load;
        n_best_time = r_best_time;
        n_lead_have = r_lead_have;
        n_lead_idx  = r_lead_idx;
        n_res       = r_res;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        qidx_ext    = '0;
        use_hint    = 1'b0;

        // drop the result once the consumer takes it
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (in_mode == MODE_SELECT) begin
                        n_db        = in_db;
                        n_type      = in_type;
                        n_hint      = in_hint;
                        n_addr      = '0;
                        n_issuing   = 1'b1;
                        n_have      = 1'b0;
                        n_lead_have = 1'b0;
                        n_state     = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_issuing) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_addr;
                    if (r_addr == IW'(ENTRIES - 1)) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (hit_hint && better) begin
                    n_have      = 1'b1;
                    n_best_idx  = r_chk_idx;
                    n_best_load = rd_attr.load;
                    n_best_time = rd_time;
                end
                if (hit_lead && !r_lead_have) begin
                    n_lead_have = 1'b1;
                    n_lead_idx  = r_chk_idx;
                end
                if (r_chk && (r_chk_idx == IW'(ENTRIES - 1))) begin
                    use_hint = r_hint && n_have;
                    if (use_hint) begin
                        qidx_ext = {{QIDX_W{1'b0}}, n_best_idx};
                        n_res    = {2'b00, 1'b0, qidx_ext[QIDX_W-1:0], 1'b1};
                    end else if (n_lead_have) begin
                        qidx_ext = {{QIDX_W{1'b0}}, n_lead_idx};
                        n_res    = {2'b00, 1'b1, qidx_ext[QIDX_W-1:0], 1'b1};
                    end else begin
                        n_res = '0;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issuing <= 1'b0;
            r_chk     <= 1'b0;
            r_m_valid <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_chk     <= n_chk;
            r_m_valid <= n_m_valid;
            r_addr    <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_db        <= n_db;
        r_type      <= n_type;
        r_hint      <= n_hint;
        r_chk_idx   <= n_chk_idx;
        r_have      <= n_have;
        r_best_idx  <= n_best_idx;
        r_best_load <= n_best_load;
        r_best_time <= n_best_time;
        r_lead_have <= n_lead_have;
        r_lead_idx  <= n_lead_idx;
        r_res       <= n_res;
        r_m_data    <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
